### rtl/hash_table_double_hashing_top_defines.svh
// Assertion macros used by the hash table top level.
`ifndef HASH_TABLE_DOUBLE_HASHING_TOP_DEFINES_SVH
`define HASH_TABLE_DOUBLE_HASHING_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define HTDH_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("htdh: same-cycle check failed");
// Next-cycle implication.
`define HTDH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("htdh: next-cycle check failed");
`else
`define HTDH_ASSERT_IMPL(label, clk, rst, ante, cons)
`define HTDH_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/htdh_pkg.sv
// Package: sizes, codes and types of the double-hashing table.
package htdh_pkg;

   localparam int TABLE_SIZE  = 17;
   localparam int IDX_W       = $clog2(TABLE_SIZE);
   localparam int KEY_W       = 31;
   localparam int OP_W        = 2;
   localparam int STATUS_W    = 3;
   localparam int SLOT_W      = 5;
   localparam int STEP_BASE   = 7;
   localparam int STEP_MOD    = 7;
   localparam int STEP_MOD_W  = 3;
   // sum of the four key bytes (256 = 1 mod 17)
   localparam int SUM17_W     = 10;
   // sum of the five 6-bit key fields and key bit 30 (64 = 1 mod 7)
   localparam int SUM7_W      = 9;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_SEARCH = 2'd1,
      OP_DELETE = 2'd2
   } htdh_op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_INSERTED  = 3'd0,
      STAT_DUPLICATE = 3'd1,
      STAT_FULL      = 3'd2,
      STAT_FOUND     = 3'd3,
      STAT_NOT_FOUND = 3'd4,
      STAT_DELETED   = 3'd5
   } htdh_status_type;

   typedef enum logic [1:0] {
      MARK_EMPTY    = 2'd0,
      MARK_DELETED  = 2'd1,
      MARK_OCCUPIED = 2'd2
   } htdh_mark_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_HASH,
      S_PROBE,
      S_DONE
   } htdh_state_type;

   // Write command from the sequencer to the slot store.
   typedef struct packed {
      logic          key_we;
      logic          mark_we;
      htdh_mark_type mark_val;
   } htdh_store_cmd_type;

endpackage

### rtl/htdh_if.sv
// Valid/ready channel interfaces for requests and responses.
interface htdh_req_if;
   import htdh_pkg::*;
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   opcode;
   logic [KEY_W-1:0]  key;
   modport source (output valid, output opcode, output key, input ready);
   modport sink (input valid, input opcode, input key, output ready);
endinterface

interface htdh_rsp_if;
   import htdh_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   slot_index;
   modport source (output valid, output status, output slot_index, input ready);
   modport sink (input valid, input status, input slot_index, output ready);
endinterface

### rtl/htdh_hash_unit.sv
// Hash unit: key folded to home slot (mod 17) and probe step (7 + mod 7).
module htdh_hash_unit
   import htdh_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [KEY_W-1:0] key,
   output logic             busy,
   output logic [IDX_W-1:0] home,
   output logic [IDX_W-1:0] step
);

   logic                  run_ff, run_in;
   logic [SUM17_W-1:0]    s17_ff, s17_in;
   logic [SUM7_W-1:0]     s7_ff, s7_in;
   logic [7:0]            g17_ff, g17_in;
   logic [4:0]            x7_ff, x7_in;

   logic [8:0]            f17;
   logic [IDX_W:0]        h_raw;
   logic [3:0]            y7;
   logic [STEP_MOD_W-1:0] r7;

   // second fold of the byte sum, at most 258
   assign f17 = {1'b0, s17_ff[7:0]} + 9'(s17_ff[9:8]);

   always_comb begin
      run_in = start;
      s17_in = s17_ff;
      s7_in  = s7_ff;
      g17_in = g17_ff;
      x7_in  = x7_ff;
      if (start) begin
         s17_in = 10'(key[7:0]) + 10'(key[15:8]) + 10'(key[23:16]) + 10'(key[30:24]);
         s7_in  = 9'(key[5:0]) + 9'(key[11:6]) + 9'(key[17:12])
                + 9'(key[23:18]) + 9'(key[29:24]) + 9'(key[30]);
      end
      if (run_ff) begin
         // f17 above 255 leaves a low byte of at most 2, so no carry out
         g17_in = f17[7:0] + 8'(f17[8]);
         // 8 = 1 mod 7: octal digits of the field sum, at most 21
         x7_in  = 5'(s7_ff[2:0]) + 5'(s7_ff[5:3]) + 5'(s7_ff[8:6]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
      s17_ff <= s17_in;
      s7_ff  <= s7_in;
      g17_ff <= g17_in;
      x7_ff  <= x7_in;
   end

   // 16 = -1 mod 17: residue is low nibble minus high nibble, kept in 0..16
   assign h_raw = (IDX_W+1)'(g17_ff[3:0]) + (IDX_W+1)'(TABLE_SIZE)
                - (IDX_W+1)'(g17_ff[7:4]);
   assign home  = (h_raw >= (IDX_W+1)'(TABLE_SIZE))
                ? IDX_W'(h_raw - (IDX_W+1)'(TABLE_SIZE))
                : IDX_W'(h_raw);

   // last octal fold, at most 10, then one subtraction of 7
   assign y7   = 4'(x7_ff[2:0]) + 4'(x7_ff[4:3]);
   assign r7   = (y7 >= 4'(STEP_MOD)) ? STEP_MOD_W'(y7 - 4'(STEP_MOD)) : STEP_MOD_W'(y7);

   // step is 7..13, always below TABLE_SIZE
   assign step = IDX_W'(STEP_BASE) + IDX_W'(r7);
   assign busy = run_ff;

endmodule

### rtl/htdh_slot_store.sv
// Slot store: key memory with registered read, slot marks in flops.
module htdh_slot_store
   import htdh_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [IDX_W-1:0]   rd_addr,
   output logic [KEY_W-1:0]   rd_key,
   input  logic [IDX_W-1:0]   slot_addr,
   output htdh_mark_type      slot_mark,
   input  htdh_store_cmd_type cmd,
   input  logic [KEY_W-1:0]   wr_key
);

   logic [KEY_W-1:0] key_mem [TABLE_SIZE];
   logic [KEY_W-1:0] rd_key_ff;
   htdh_mark_type    marks_ff [TABLE_SIZE];

   always_ff @(posedge clock) begin
      if (cmd.key_we) begin
         key_mem[slot_addr] <= wr_key;
      end
      rd_key_ff <= key_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_SIZE; i++) begin
            marks_ff[i] <= MARK_EMPTY;
         end
      end else if (cmd.mark_we) begin
         marks_ff[slot_addr] <= cmd.mark_val;
      end
   end

   assign rd_key    = rd_key_ff;
   assign slot_mark = marks_ff[slot_addr];

endmodule

### rtl/hash_table_double_hashing_top.sv
// Top level: double-hashing table sequencer with hash unit and slot store.
//
//   channel   modport   payload                       role
//   req_chan  sink      opcode[1:0], key[30:0]        insert / search / delete
//   rsp_chan  source    status[2:0], slot_index[4:0]  one response per request
//
// Sequence: a transaction is accepted in idle, then hashed (the key folded by
//   bytes for mod 17 and by 6-bit fields for mod 7) while S_HASH waits on the
//   hash unit and loads home and step, then probed at 1 to TABLE_SIZE slots
//   (one key memory read per probe), then answered with one response.
// Opcode 3 skips hashing: the accept is followed by the response.
// Reset (synchronous) clears the slot marks to empty.
// req_chan.ready is high only in idle; a held response stalls the block.
`include "hash_table_double_hashing_top_defines.svh"
module hash_table_double_hashing_top
   import htdh_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   htdh_req_if.sink   req_chan,
   htdh_rsp_if.source rsp_chan
);

   htdh_state_type     state_ff, state_in;
   htdh_op_type        op_ff, op_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [IDX_W-1:0]   loc_ff, loc_in;
   logic [IDX_W-1:0]   cnt_ff, cnt_in;
   htdh_status_type    status_ff, status_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;

   logic               hash_start;
   logic               hash_busy;
   logic [IDX_W-1:0]   hash_home;
   logic [IDX_W-1:0]   hash_step;
   logic [IDX_W-1:0]   step_ff, step_in;

   logic [KEY_W-1:0]   rd_key;
   htdh_mark_type      slot_mark;
   htdh_store_cmd_type store_cmd;

   logic [IDX_W:0]     loc_sum;
   logic [IDX_W-1:0]   loc_next;
   logic               last_probe;
   logic               key_hit;

   htdh_hash_unit u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .key   (key_in),
      .busy  (hash_busy),
      .home  (hash_home),
      .step  (hash_step)
   );

   // key read address follows the next probe slot so data lines up with loc_ff
   htdh_slot_store u_store (
      .clock     (clock),
      .reset     (reset),
      .rd_addr   (loc_in),
      .rd_key    (rd_key),
      .slot_addr (loc_ff),
      .slot_mark (slot_mark),
      .cmd       (store_cmd),
      .wr_key    (key_ff)
   );

   // probe advance: loc and step are both below TABLE_SIZE
   assign loc_sum    = {1'b0, loc_ff} + {1'b0, step_ff};
   assign loc_next   = (loc_sum >= (IDX_W+1)'(TABLE_SIZE))
                     ? IDX_W'(loc_sum - (IDX_W+1)'(TABLE_SIZE))
                     : IDX_W'(loc_sum);
   assign last_probe = (cnt_ff == IDX_W'(TABLE_SIZE - 1));
   assign key_hit    = (rd_key == key_ff);

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      key_in     = key_ff;
      loc_in     = loc_ff;
      cnt_in     = cnt_ff;
      step_in    = step_ff;
      status_in  = status_ff;
      slot_in    = slot_ff;
      hash_start = 1'b0;
      store_cmd  = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               op_in  = htdh_op_type'(req_chan.opcode);
               key_in = req_chan.key;
               case (req_chan.opcode)
                  OP_INSERT, OP_SEARCH, OP_DELETE: begin
                     hash_start = 1'b1;
                     state_in   = S_HASH;
                  end
                  default: begin
                     // unused opcode: table untouched
                     status_in = STAT_NOT_FOUND;
                     slot_in   = '0;
                     state_in  = S_DONE;
                  end
               endcase
            end
         end

         S_HASH: begin
            if (!hash_busy) begin
               loc_in   = hash_home;
               step_in  = hash_step;
               cnt_in   = '0;
               state_in = S_PROBE;
            end
         end

         S_PROBE: begin
            if (op_ff == OP_INSERT) begin
               if (slot_mark != MARK_OCCUPIED) begin
                  store_cmd.key_we   = 1'b1;
                  store_cmd.mark_we  = 1'b1;
                  store_cmd.mark_val = MARK_OCCUPIED;
                  status_in          = STAT_INSERTED;
                  slot_in            = SLOT_W'(loc_ff);
                  state_in           = S_DONE;
               end else if (key_hit) begin
                  status_in = STAT_DUPLICATE;
                  slot_in   = '0;
                  state_in  = S_DONE;
               end else if (last_probe) begin
                  status_in = STAT_FULL;
                  slot_in   = '0;
                  state_in  = S_DONE;
               end else begin
                  loc_in = loc_next;
                  cnt_in = cnt_ff + 1'b1;
               end
            end else begin
               if (slot_mark == MARK_EMPTY) begin
                  status_in = STAT_NOT_FOUND;
                  slot_in   = '0;
                  state_in  = S_DONE;
               end else if (slot_mark == MARK_OCCUPIED && key_hit) begin
                  slot_in  = SLOT_W'(loc_ff);
                  state_in = S_DONE;
                  if (op_ff == OP_DELETE) begin
                     store_cmd.mark_we  = 1'b1;
                     store_cmd.mark_val = MARK_DELETED;
                     status_in          = STAT_DELETED;
                  end else begin
                     status_in = STAT_FOUND;
                  end
               end else if (last_probe) begin
                  status_in = STAT_NOT_FOUND;
                  slot_in   = '0;
                  state_in  = S_DONE;
               end else begin
                  loc_in = loc_next;
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end

         S_DONE: begin
            if (rsp_chan.ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff     <= op_in;
      key_ff    <= key_in;
      loc_ff    <= loc_in;
      cnt_ff    <= cnt_in;
      step_ff   <= step_in;
      status_ff <= status_in;
      slot_ff   <= slot_in;
   end

   assign req_chan.ready      = (state_ff == S_IDLE);
   assign rsp_chan.valid      = (state_ff == S_DONE);
   assign rsp_chan.status     = status_ff;
   assign rsp_chan.slot_index = slot_ff;

   `HTDH_ASSERT_IMPL(a_loc_in_range, clock, reset, state_ff == S_PROBE, loc_ff < IDX_W'(TABLE_SIZE))
   `HTDH_ASSERT_IMPL(a_step_in_range, clock, reset, state_ff == S_PROBE, step_ff < IDX_W'(TABLE_SIZE))
   `HTDH_ASSERT_IMPL(a_no_accept_busy, clock, reset, rsp_chan.valid, !req_chan.ready)
   `HTDH_ASSERT_NEXT(a_insert_reports, clock, reset, store_cmd.key_we, state_ff == S_DONE && status_ff == STAT_INSERTED)
   `HTDH_ASSERT_NEXT(a_hash_done_probe, clock, reset, state_ff == S_HASH && !hash_busy, state_ff == S_PROBE && cnt_ff == '0)

endmodule
